// ----- hdl/tdd_pkg.sv -----
package tdd_pkg;

   // Stream payload widths (whole bytes)
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 96;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_DRIFT_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SUPPRESS_WINDOW = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_COUNT      = 2'd2;

   // Register defaults, also used when a register holds zero
   localparam logic [14:0] DEF_THRESHOLD  = 15'd50;
   localparam logic [31:0] DEF_SUPPRESS   = 32'd300000;
   localparam logic [7:0]  DEF_BASE_COUNT = 8'd5;

   // Timing constants
   localparam logic [31:0] COOLDOWN_MS  = 32'd600000;
   localparam logic [31:0] BUCKET_MS    = 32'd600000;
   localparam logic [31:0] BUCKET_COUNT = 32'd144;

   // Bucket by reciprocals: now / 600000 is (now >> 6) / 9375, exact for all
   // 26-bit dividends; q mod 144 goes through (q >> 4) / 9, exact below 1170
   localparam logic [26:0] BKT_MS_RECIP  = 27'd117281241;
   localparam int          BKT_MS_SHIFT  = 40;
   localparam logic [9:0]  BKT_CNT_RECIP = 10'd911;
   localparam int          BKT_CNT_SHIFT = 13;

   // Sample range and confidence limits
   localparam logic signed [15:0] TEMP_LIMIT = 16'sd30000;
   localparam logic [6:0] CONF_BASE = 7'd50;
   localparam logic [6:0] CONF_MAX  = 7'd100;

   // Shared divider
   localparam int DIV_W     = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Reciprocal of ten, exact for dividends below 69905
   localparam logic [18:0] RND_MUL   = 19'd419431;
   localparam int          RND_SHIFT = 22;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } tdd_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } tdd_div_rsp_type;

   // Round tenths half away from zero to whole degrees, saturate to 8 bits
   function automatic logic signed [7:0] round_degrees(input logic signed [15:0] t);
      logic [15:0] mag;
      logic [34:0] prod;
      logic [12:0] q;
      logic [7:0]  res;
      mag  = t[15] ? 16'(-t) : 16'(t);
      prod = 35'(mag + 16'd5) * 35'(RND_MUL);
      q    = prod[RND_SHIFT +: 13];
      if (!t[15]) begin
         res = (q > 13'd127) ? 8'd127 : q[7:0];
      end else begin
         res = (q > 13'd128) ? 8'h80 : (8'd0 - q[7:0]);
      end
      return $signed(res);
   endfunction

endpackage

// ----- hdl/tdd_div.sv -----
module tdd_div (
   input  logic                     clock,
   input  logic                     reset,
   input  tdd_pkg::tdd_div_req_type div_req,
   output tdd_pkg::tdd_div_rsp_type div_rsp
);
   import tdd_pkg::*;

   typedef enum logic {DV_IDLE, DV_RUN} dv_state_type;

   dv_state_type         state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic                 done_ff, done_in;

   logic [DIV_W:0]       trial;
   logic                 fits;

   // One restoring step: shift in the next dividend bit, subtract when it fits
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         DV_IDLE: begin
            if (div_req.start) begin
               quo_in   = div_req.dividend;
               den_in   = div_req.divisor;
               rem_in   = '0;
               cnt_in   = DIV_CNT_W'(DIV_W - 1);
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in = fits ? DIV_W'(trial - {1'b0, den_ff}) : trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         cnt_ff   <= '0;
         quo_ff   <= '0;
         rem_ff   <= '0;
         den_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         quo_ff   <= quo_in;
         rem_ff   <= rem_in;
         den_ff   <= den_in;
         done_ff  <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

// ----- hdl/temperature_drift_detector_core.sv -----
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  req_tdata, req_tuser (func)
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata, rsp_tuser (event_valid)
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// One item at a time, each from PREP on: a load update or a building sample to OUT; a nudge
// EVAL, BROUND, OUT; a suppressed drift EVAL, OUT; the locking sample MEAN (mean on the
// 32-step serial divider), BROUND, OUT; an event EVAL, CONF (confidence on the divider),
// BUCK1, BUCK2 (two reciprocal multiplies for the time bucket), OUT. req_tready is high
// only while idle; a waiting result does not block it, but the next result holds until
// that transfer. csr_ready is always high. Reset is synchronous and needs no clearing pass.
module temperature_drift_detector_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] now_ms, [47:32] temp_tenths, [48] load_active, [55:49] zero
   input  logic [tdd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] func
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [6:0] confidence, [14:7] ten-minute slot, [15] lock flag,
   // [23:16] baseline_degrees, [31:24] last_degrees, [63:32] samples_seen,
   // [95:64] events_raised
   output logic [tdd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] event_valid
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tdd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tdd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import tdd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_EVAL, ST_MEAN, ST_BROUND,
      ST_CONF, ST_BUCK1, ST_BUCK2, ST_OUT
   } st_type;

   // Configuration
   logic [14:0] thr_ff;
   logic [31:0] sup_ff;
   logic [7:0]  need_ff;
   logic [14:0] thr_eff;
   logic [31:0] sup_eff;
   logic [7:0]  need_eff;

   // Sequencer and item
   st_type             state_ff, state_in;
   logic               func_ff, func_in;
   logic [31:0]        now_ff, now_in;
   logic signed [15:0] temp_ff, temp_in;
   logic               load_ff, load_in;

   // Detector state
   logic signed [23:0] sum_ff, sum_in;
   logic [7:0]         bss_ff, bss_in;
   logic signed [15:0] base_ff, base_in;
   logic               locked_ff, locked_in;
   logic               hload_ff, hload_in;
   logic [31:0]        cool_dl_ff, cool_dl_in;
   logic [31:0]        last_ev_ff, last_ev_in;
   logic [31:0]        smp_cnt_ff, smp_cnt_in;
   logic [31:0]        ev_cnt_ff, ev_cnt_in;
   logic signed [7:0]  last_rnd_ff, last_rnd_in;
   logic signed [7:0]  base_rnd_ff, base_rnd_in;

   // Per-item work
   logic signed [16:0] delta_ff, delta_in;
   logic               mean_neg_ff, mean_neg_in;
   logic               ev_ff, ev_in;
   logic [6:0]         conf_ff, conf_in;
   logic [7:0]         bucket_ff, bucket_in;
   logic [12:0]        bkt_q_ff, bkt_q_in;

   // Divider and result
   tdd_div_req_type         div_req_ff, div_req_in;
   tdd_div_rsp_type         div_rsp;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic                    rsp_tuser_ff, rsp_tuser_in;

   // Datapath terms
   logic signed [15:0] req_temp;
   logic signed [23:0] sum_new;
   logic [23:0]        sum_mag;
   logic [7:0]         bss_new;
   logic [15:0]        mag;
   logic [15:0]        mag_over;
   logic [21:0]        conf_num;
   logic [31:0]        cool_diff;
   logic               cooling;
   logic [52:0]        bkt_prod;
   logic [21:0]        bkt_hi_prod;
   logic [12:0]        bkt_rem;

   // Move the baseline toward the sample by delta >> sh, toward zero, step at least 1
   function automatic logic signed [15:0] nudge_base(input logic signed [15:0] base,
                                                     input logic signed [16:0] delta,
                                                     input logic big_div);
      logic [16:0]        m;
      logic [16:0]        q;
      logic signed [16:0] adj;
      m = delta[16] ? 17'(-delta) : 17'(delta);
      q = big_div ? (m >> 4) : (m >> 1);
      if (q == '0 && m != '0) begin
         q = 17'd1;
      end
      adj = delta[16] ? -$signed(q) : $signed(q);
      return 16'(17'(base) + adj);
   endfunction

   tdd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   // Take register writes; zero selects the default
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= DEF_THRESHOLD;
         sup_ff  <= DEF_SUPPRESS;
         need_ff <= DEF_BASE_COUNT;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_DRIFT_THRESHOLD: thr_ff  <= csr_data[14:0];
            REG_SUPPRESS_WINDOW: sup_ff  <= csr_data;
            REG_BASE_COUNT:      need_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign thr_eff   = (thr_ff == '0) ? DEF_THRESHOLD : thr_ff;
   assign sup_eff   = (sup_ff == '0) ? DEF_SUPPRESS : sup_ff;
   assign need_eff  = (need_ff == '0) ? DEF_BASE_COUNT : need_ff;

   // Clamp the incoming sample
   always_comb begin
      req_temp = $signed(req_tdata[47:32]);
      if (req_temp > TEMP_LIMIT) begin
         req_temp = TEMP_LIMIT;
      end else if (req_temp < -TEMP_LIMIT) begin
         req_temp = -TEMP_LIMIT;
      end
   end

   assign sum_new   = sum_ff + 24'(temp_ff);
   assign sum_mag   = sum_new[23] ? 24'(-sum_new) : 24'(sum_new);
   assign bss_new   = bss_ff + 8'd1;
   assign mag       = delta_ff[16] ? 16'(-delta_ff) : 16'(delta_ff);
   assign mag_over  = mag - 16'(thr_eff);
   assign conf_num  = 22'(mag_over) * 22'(CONF_BASE);
   assign cool_diff = now_ff - cool_dl_ff;
   assign cooling   = cool_diff[31];

   // Bucket: ten-minute index from (now >> 6) / 9375, then its remainder modulo 144
   assign bkt_prod    = 53'(now_ff[31:6]) * 53'(BKT_MS_RECIP);
   assign bkt_hi_prod = 22'(bkt_q_ff[12:4]) * 22'(BKT_CNT_RECIP);
   assign bkt_rem     = bkt_q_ff - 13'(bkt_hi_prod[21:BKT_CNT_SHIFT]) * 13'(BUCKET_COUNT);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      now_in        = now_ff;
      temp_in       = temp_ff;
      load_in       = load_ff;
      sum_in        = sum_ff;
      bss_in        = bss_ff;
      base_in       = base_ff;
      locked_in     = locked_ff;
      hload_in      = hload_ff;
      cool_dl_in    = cool_dl_ff;
      last_ev_in    = last_ev_ff;
      smp_cnt_in    = smp_cnt_ff;
      ev_cnt_in     = ev_cnt_ff;
      last_rnd_in   = last_rnd_ff;
      base_rnd_in   = base_rnd_ff;
      delta_in      = delta_ff;
      mean_neg_in   = mean_neg_ff;
      ev_in         = ev_ff;
      conf_in       = conf_ff;
      bucket_in     = bucket_ff;
      bkt_q_in      = bkt_q_ff;
      div_req_in    = div_req_ff;
      div_req_in.start = 1'b0;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      unique case (state_ff)
         // Capture the item
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in   = req_tuser;
               now_in    = req_tdata[31:0];
               temp_in   = req_temp;
               load_in   = req_tdata[48];
               ev_in     = 1'b0;
               conf_in   = '0;
               bucket_in = '0;
               state_in  = ST_PREP;
            end
         end
         // Load update, or common sample bookkeeping
         ST_PREP: begin
            if (func_ff) begin
               if (hload_ff && !load_ff) begin
                  cool_dl_in = now_ff + COOLDOWN_MS;
               end
               hload_in = load_ff;
               state_in = ST_OUT;
            end else begin
               smp_cnt_in  = smp_cnt_ff + 32'd1;
               last_rnd_in = round_degrees(temp_ff);
               if (!locked_ff) begin
                  sum_in = sum_new;
                  bss_in = bss_new;
                  if (bss_new >= need_eff && bss_new != '0) begin
                     mean_neg_in         = sum_new[23];
                     div_req_in.start    = 1'b1;
                     div_req_in.dividend = DIV_W'(sum_mag);
                     div_req_in.divisor  = DIV_W'(bss_new);
                     state_in            = ST_MEAN;
                  end else begin
                     state_in = ST_OUT;
                  end
               end else begin
                  delta_in = 17'(temp_ff) - 17'(base_ff);
                  state_in = ST_EVAL;
               end
            end
         end
         // Detect, or track the baseline
         ST_EVAL: begin
            if (hload_ff || cooling) begin
               base_in  = nudge_base(base_ff, delta_ff, 1'b0);
               state_in = ST_BROUND;
            end else if (mag >= 16'(thr_eff)) begin
               if ((now_ff - last_ev_ff) >= sup_eff) begin
                  ev_in               = 1'b1;
                  ev_cnt_in           = ev_cnt_ff + 32'd1;
                  last_ev_in          = now_ff;
                  div_req_in.start    = 1'b1;
                  div_req_in.dividend = DIV_W'(conf_num);
                  div_req_in.divisor  = DIV_W'(thr_eff);
                  state_in            = ST_CONF;
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               base_in  = nudge_base(base_ff, delta_ff, 1'b1);
               state_in = ST_BROUND;
            end
         end
         // Lock the baseline at the mean
         ST_MEAN: begin
            if (div_rsp.done) begin
               base_in   = mean_neg_ff ? -$signed(div_rsp.quot[15:0])
                                       : $signed(div_rsp.quot[15:0]);
               locked_in = 1'b1;
               state_in  = ST_BROUND;
            end
         end
         ST_BROUND: begin
            base_rnd_in = round_degrees(base_ff);
            state_in    = ST_OUT;
         end
         // Confidence, then the bucket index
         ST_CONF: begin
            if (div_rsp.done) begin
               conf_in = (div_rsp.quot >= DIV_W'(CONF_BASE)) ? CONF_MAX
                                                             : CONF_BASE + div_rsp.quot[6:0];
               state_in = ST_BUCK1;
            end
         end
         ST_BUCK1: begin
            bkt_q_in = bkt_prod[BKT_MS_SHIFT +: 13];
            state_in = ST_BUCK2;
         end
         ST_BUCK2: begin
            bucket_in = bkt_rem[7:0];
            state_in  = ST_OUT;
         end
         // Hold until the output register is free
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tdata_in  = {ev_cnt_ff, smp_cnt_ff, last_rnd_ff, base_rnd_ff,
                                locked_ff, bucket_ff, conf_ff};
               rsp_tuser_in  = ev_ff;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         func_ff       <= 1'b0;
         now_ff        <= '0;
         temp_ff       <= '0;
         load_ff       <= 1'b0;
         sum_ff        <= '0;
         bss_ff        <= '0;
         base_ff       <= '0;
         locked_ff     <= 1'b0;
         hload_ff      <= 1'b0;
         cool_dl_ff    <= '0;
         last_ev_ff    <= '0;
         smp_cnt_ff    <= '0;
         ev_cnt_ff     <= '0;
         last_rnd_ff   <= '0;
         base_rnd_ff   <= '0;
         delta_ff      <= '0;
         mean_neg_ff   <= 1'b0;
         ev_ff         <= 1'b0;
         conf_ff       <= '0;
         bucket_ff     <= '0;
         bkt_q_ff      <= '0;
         div_req_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_tdata_ff  <= '0;
         rsp_tuser_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         func_ff       <= func_in;
         now_ff        <= now_in;
         temp_ff       <= temp_in;
         load_ff       <= load_in;
         sum_ff        <= sum_in;
         bss_ff        <= bss_in;
         base_ff       <= base_in;
         locked_ff     <= locked_in;
         hload_ff      <= hload_in;
         cool_dl_ff    <= cool_dl_in;
         last_ev_ff    <= last_ev_in;
         smp_cnt_ff    <= smp_cnt_in;
         ev_cnt_ff     <= ev_cnt_in;
         last_rnd_ff   <= last_rnd_in;
         base_rnd_ff   <= base_rnd_in;
         delta_ff      <= delta_in;
         mean_neg_ff   <= mean_neg_in;
         ev_ff         <= ev_in;
         conf_ff       <= conf_in;
         bucket_ff     <= bucket_in;
         bkt_q_ff      <= bkt_q_in;
         div_req_ff    <= div_req_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rsp_tdata_ff  <= rsp_tdata_in;
         rsp_tuser_ff  <= rsp_tuser_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ----- hdl/tdd_checker.sv -----
module tdd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tdd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                              rsp_tuser
);
   import tdd_pkg::*;

   // Busy after taking an item
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an input transfer");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // An event carries a legal confidence and bucket from a locked baseline
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[6:0] >= CONF_BASE
                                     && rsp_tdata[6:0] <= CONF_MAX
                                     && rsp_tdata[14:7] < 8'(BUCKET_COUNT)
                                     && rsp_tdata[15]))
      else $error("event result out of range");

   // No event, no confidence and no bucket
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[6:0] == '0 && rsp_tdata[14:7] == '0))
      else $error("non-event result carries event fields");

endmodule

bind temperature_drift_detector_core tdd_checker u_tdd_checker (.*);
